### rtl/kcl_pkg.sv
// Shared types and constants for the keypad code lock.
// Used by kcl_debounce, kcl_ctrl and keypad_code_lock_with_lockout.
package kcl_pkg;

	// Default number of digits in one code
	localparam int CODE_DIGITS_DEF = 3;

	// Configuration register indexes
	localparam logic [2:0] REG_USER_CODE   = 3'd0;
	localparam logic [2:0] REG_ADMIN_CODE  = 3'd1;
	localparam logic [2:0] REG_DEBOUNCE    = 3'd2;
	localparam logic [2:0] REG_OPEN        = 3'd3;
	localparam logic [2:0] REG_BLINK_HALF  = 3'd4;
	localparam logic [2:0] REG_WARN_TOGGLE = 3'd5;
	localparam logic [2:0] REG_LOCKDOWN    = 3'd6;

	localparam int CFG_DATA_W = 18;

	// Configuration reset values
	localparam logic [5:0]  USER_CODE_RST   = 6'd27;
	localparam logic [5:0]  ADMIN_CODE_RST  = 6'd0;
	localparam logic [7:0]  DEBOUNCE_RST    = 8'd20;
	localparam logic [15:0] OPEN_RST        = 16'd5000;
	localparam logic [15:0] BLINK_HALF_RST  = 16'd500;
	localparam logic [7:0]  WARN_TOGGLE_RST = 8'd20;
	localparam logic [17:0] LOCKDOWN_RST    = 18'd120000;

	localparam logic [17:0] TIMER_MAX = 18'h3FFFF;

	// LED vector layout: bit0 green, bit1 blue, bit2 red
	localparam logic [2:0] LED_G = 3'b001;
	localparam logic [2:0] LED_B = 3'b010;
	localparam logic [2:0] LED_R = 3'b100;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_ACCEPTED    = 3'd1,
		EV_WRONG       = 3'd2,
		EV_WARNING     = 3'd3,
		EV_LOCKDOWN    = 3'd4,
		EV_ADMIN_OK    = 3'd5,
		EV_ADMIN_WRONG = 3'd6,
		EV_EXPIRED     = 3'd7
	} kcl_event_t;

	typedef struct packed {
		logic [5:0]  user_code;
		logic [5:0]  admin_code;
		logic [7:0]  debounce_ticks;
		logic [15:0] open_ticks;
		logic [15:0] blink_half_ticks;
		logic [7:0]  warning_toggles;
		logic [17:0] lockdown_ticks;
	} kcl_cfg_t;

	// Debouncer to lock controller: one released digit
	typedef struct packed {
		logic       taken;
		logic [1:0] digit;
	} kcl_digit_t;

	// One result item
	typedef struct packed {
		logic       led_green;
		logic       led_blue;
		logic       led_red;
		logic       digit_taken;
		kcl_event_t event_code;
		logic [1:0] failure_count;
	} kcl_result_t;

endpackage

### rtl/kcl_debounce.sv
// Button debouncer: picks a candidate digit, confirms it, reports it on release.
// Depends on kcl_pkg.
module kcl_debounce (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [3:0]        buttons,
	input  logic [7:0]        debounce_ticks,
	output kcl_pkg::kcl_digit_t dig
);
	import kcl_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_DEBOUNCE = 3'b010,
		PH_RELEASE = 3'b100
	} kcl_phase_t;

	kcl_phase_t phase_q, phase_n;
	logic [1:0] cand_q, cand_n;
	logic [7:0] cnt_q, cnt_n, cnt_inc;
	logic       held;
	logic [1:0] held_bit;

	// Button bit that the candidate digit maps to
	assign held_bit = (cand_q == 2'd0) ? 2'd3 : (cand_q - 2'd1);
	assign held     = buttons[held_bit];
	assign cnt_inc  = (cnt_q != 8'hFF) ? (cnt_q + 8'd1) : cnt_q;

	// Next press state
	always_comb begin
		phase_n   = phase_q;
		cand_n    = cand_q;
		cnt_n     = cnt_q;
		dig.taken = 1'b0;
		dig.digit = cand_q;
		case (phase_q)
			PH_IDLE: begin
				if (buttons != 4'd0) begin
					if (buttons[0])      cand_n = 2'd1;
					else if (buttons[1]) cand_n = 2'd2;
					else if (buttons[2]) cand_n = 2'd3;
					else                 cand_n = 2'd0;
					cnt_n   = 8'd0;
					phase_n = (debounce_ticks == 8'd0) ? PH_RELEASE : PH_DEBOUNCE;
				end
			end
			PH_DEBOUNCE: begin
				if (!held) begin
					phase_n = PH_IDLE;
				end else begin
					cnt_n = cnt_inc;
					if (cnt_inc >= debounce_ticks) phase_n = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (!held) begin
					phase_n   = PH_IDLE;
					dig.taken = 1'b1;
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
	end

	// Advance on each sample taken while scanning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cand_q  <= 2'd0;
			cnt_q   <= 8'd0;
		end else if (step) begin
			phase_q <= phase_n;
			cand_q  <= cand_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule

### rtl/kcl_ctrl.sv
// Lock state machine: code entry, checking, open, warning and lockdown timing.
// Depends on kcl_pkg; takes digits from kcl_debounce.
module kcl_ctrl #(
	parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  kcl_pkg::kcl_cfg_t    cfg,
	input  kcl_pkg::kcl_digit_t  dig,
	output logic                 scan_en,
	output kcl_pkg::kcl_result_t res
);
	import kcl_pkg::*;

	localparam int EW = 2 * CODE_DIGITS;
	localparam int DW = $clog2(CODE_DIGITS + 1);

	typedef enum logic [3:0] {
		MODE_LOCKED   = 4'b0001,
		MODE_OPEN     = 4'b0010,
		MODE_WARN     = 4'b0100,
		MODE_LOCKDOWN = 4'b1000
	} kcl_mode_t;

	kcl_mode_t   mode_q, mode_n;
	logic [1:0]  wrong_q, wrong_n, wrong_fail;
	logic        wend_q, wend_n;
	logic [17:0] phase_q, phase_n, phase_inc;
	logic [15:0] blink_q, blink_n, blink_inc, half;
	logic [7:0]  tog_q, tog_n;
	logic [2:0]  led_q, led_n;
	logic [EW-1:0] entry_q, entry_n, entry_new;
	logic [DW-1:0] cnt_q, cnt_n;
	logic [EW+1:0] shift_w;
	logic [EW+5:0] ucode_w, acode_w;
	logic        done;
	kcl_event_t  ev;

	assign scan_en = (mode_q == MODE_LOCKED) || (mode_q == MODE_LOCKDOWN);

	// Entry shifted by the new digit, codes sized to the entry width
	assign shift_w   = {entry_q, dig.digit};
	assign entry_new = shift_w[EW-1:0];
	assign ucode_w   = {{EW{1'b0}}, cfg.user_code};
	assign acode_w   = {{EW{1'b0}}, cfg.admin_code};
	assign done      = scan_en && dig.taken && (cnt_q == DW'(CODE_DIGITS - 1));

	assign phase_inc  = (phase_q < TIMER_MAX) ? (phase_q + 18'd1) : phase_q;
	assign blink_inc  = blink_q + 16'd1;
	assign half       = (cfg.blink_half_ticks == 16'd0) ? 16'd1 : cfg.blink_half_ticks;
	assign wrong_fail = wend_q ? 2'd3 : ((wrong_q != 2'd3) ? (wrong_q + 2'd1) : 2'd3);

	// Next lock state and result
	always_comb begin
		mode_n  = mode_q;
		wrong_n = wrong_q;
		wend_n  = wend_q;
		phase_n = phase_q;
		blink_n = blink_q;
		tog_n   = tog_q;
		led_n   = led_q;
		entry_n = entry_q;
		cnt_n   = cnt_q;
		ev      = EV_NONE;

		// Collect a digit; drop the entry once complete
		if (scan_en && dig.taken) begin
			if (done) begin
				entry_n = '0;
				cnt_n   = '0;
			end else begin
				entry_n = entry_new;
				cnt_n   = cnt_q + DW'(1);
			end
		end

		case (mode_q)
			MODE_LOCKED: begin
				if (done) begin
					if (entry_new == ucode_w[EW-1:0]) begin
						wrong_n = 2'd0;
						wend_n  = 1'b0;
						mode_n  = MODE_OPEN;
						phase_n = 18'd0;
						led_n   = LED_G;
						ev      = EV_ACCEPTED;
					end else begin
						wrong_n = wrong_fail;
						wend_n  = 1'b0;
						if (wrong_fail == 2'd2) begin
							ev = EV_WARNING;
							if (cfg.warning_toggles == 8'd0) begin
								led_n  = LED_R;
								wend_n = 1'b1;
							end else begin
								mode_n  = MODE_WARN;
								blink_n = 16'd0;
								led_n   = led_q ^ LED_R;
								tog_n   = 8'd1;
							end
						end else if (wrong_fail == 2'd3) begin
							ev      = EV_LOCKDOWN;
							mode_n  = MODE_LOCKDOWN;
							phase_n = 18'd0;
							blink_n = 16'd0;
							led_n   = led_q | LED_B;
						end else begin
							ev = EV_WRONG;
						end
					end
				end
			end
			MODE_OPEN: begin
				phase_n = phase_inc;
				if (phase_inc >= {2'b00, cfg.open_ticks}) begin
					mode_n = MODE_LOCKED;
					led_n  = LED_R;
				end
			end
			MODE_WARN: begin
				blink_n = blink_inc;
				if (blink_inc >= half) begin
					blink_n = 16'd0;
					if (tog_q >= cfg.warning_toggles) begin
						mode_n = MODE_LOCKED;
						led_n  = LED_R;
						wend_n = 1'b1;
					end else begin
						led_n = led_q ^ LED_R;
						tog_n = tog_q + 8'd1;
					end
				end
			end
			MODE_LOCKDOWN: begin
				if (done && (entry_new == acode_w[EW-1:0])) begin
					wrong_n = 2'd0;
					wend_n  = 1'b0;
					mode_n  = MODE_LOCKED;
					led_n   = LED_R;
					ev      = EV_ADMIN_OK;
				end else begin
					if (done) ev = EV_ADMIN_WRONG;
					phase_n = phase_inc;
					blink_n = blink_inc;
					if (blink_inc >= half) begin
						blink_n = 16'd0;
						led_n   = led_q ^ LED_R;
					end
					if (phase_inc >= cfg.lockdown_ticks) begin
						mode_n  = MODE_LOCKED;
						led_n   = LED_R;
						entry_n = '0;
						cnt_n   = '0;
						ev      = EV_EXPIRED;
					end
				end
			end
			default: begin
				mode_n = MODE_LOCKED;
			end
		endcase

		res.led_green     = led_n[0];
		res.led_blue      = led_n[1];
		res.led_red       = led_n[2];
		res.digit_taken   = scan_en && dig.taken;
		res.event_code    = ev;
		res.failure_count = wrong_n;
	end

	// Advance state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LOCKED;
			wrong_q <= 2'd0;
			wend_q  <= 1'b0;
			phase_q <= 18'd0;
			blink_q <= 16'd0;
			tog_q   <= 8'd0;
			led_q   <= LED_R;
			entry_q <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			mode_q  <= mode_n;
			wrong_q <= wrong_n;
			wend_q  <= wend_n;
			phase_q <= phase_n;
			blink_q <= blink_n;
			tog_q   <= tog_n;
			led_q   <= led_n;
			entry_q <= entry_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule

### rtl/keypad_code_lock_with_lockout.sv
// Top level of the keypad code lock: configuration registers, handshake, result register.
// Depends on kcl_pkg, kcl_debounce and kcl_ctrl.
//
// Each transfer on the input channel is one tick's sample of the four buttons; each
// produces exactly one result (LED levels, digit pulse, event code, failure count).
// The block takes one sample per clock cycle unless in_stall holds it off; the result
// appears in the output register on the cycle after the transfer, since the single
// result register is the only register on the path: debouncing, code checking and
// all timers are updated in one pass of logic per sample. A new sample is taken while
// a result waits, as long as that result is taken in the same cycle. Configuration
// writes take effect at once and should be issued only while no result is outstanding.
module keypad_code_lock_with_lockout #(
	parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [3:0]                    buttons,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          led_green,
	output logic                          led_blue,
	output logic                          led_red,
	output logic                          digit_taken,
	output logic [2:0]                    event_code,
	output logic [1:0]                    failure_count,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kcl_pkg::*;

	kcl_cfg_t    cfg_q;
	kcl_digit_t  dig;
	kcl_result_t res, res_s1;
	logic        scan_en;
	logic        accept;
	logic        out_valid_q;

	// Stall only when a result waits and is not being taken
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.user_code        <= USER_CODE_RST;
			cfg_q.admin_code       <= ADMIN_CODE_RST;
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.open_ticks       <= OPEN_RST;
			cfg_q.blink_half_ticks <= BLINK_HALF_RST;
			cfg_q.warning_toggles  <= WARN_TOGGLE_RST;
			cfg_q.lockdown_ticks   <= LOCKDOWN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_USER_CODE:   cfg_q.user_code        <= cfg_data[5:0];
				REG_ADMIN_CODE:  cfg_q.admin_code       <= cfg_data[5:0];
				REG_DEBOUNCE:    cfg_q.debounce_ticks   <= cfg_data[7:0];
				REG_OPEN:        cfg_q.open_ticks       <= cfg_data[15:0];
				REG_BLINK_HALF:  cfg_q.blink_half_ticks <= cfg_data[15:0];
				REG_WARN_TOGGLE: cfg_q.warning_toggles  <= cfg_data[7:0];
				REG_LOCKDOWN:    cfg_q.lockdown_ticks   <= cfg_data[17:0];
				default: begin
				end
			endcase
		end
	end

	kcl_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (accept && scan_en),
		.buttons        (buttons),
		.debounce_ticks (cfg_q.debounce_ticks),
		.dig            (dig)
	);

	kcl_ctrl #(
		.CODE_DIGITS (CODE_DIGITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.cfg     (cfg_q),
		.dig     (dig),
		.scan_en (scan_en),
		.res     (res)
	);

	// Result register: load on transfer, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign led_green     = res_s1.led_green;
	assign led_blue      = res_s1.led_blue;
	assign led_red       = res_s1.led_red;
	assign digit_taken   = res_s1.digit_taken;
	assign event_code    = res_s1.event_code;
	assign failure_count = res_s1.failure_count;

endmodule

### tb/keypad_code_lock_with_lockout_tb.sv
// Self-checking testbench for the keypad code lock with lockout.
// Depends on kcl_pkg and keypad_code_lock_with_lockout; a scoreboard class predicts each tick.
`timescale 1ns / 1ps

module keypad_code_lock_with_lockout_tb;
	import kcl_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int CODE_LEN       = 3;

	// Opening sequence, first sample in the top nibble
	localparam logic [31*4-1:0] OPENING_KEYS = {
		4'd15, 4'd0, 4'd2, 4'd0, 4'd4, 4'd0, 4'd0,
		4'd14, 4'd0, 4'd12, 4'd0, 4'd8, 4'd0,
		4'd8, 4'd0, 4'd8, 4'd0, 4'd8, 4'd0,
		4'd3, 4'd0, 4'd3, 4'd0, 4'd3, 4'd0,
		4'd8, 4'd0, 4'd8, 4'd0, 4'd8, 4'd0
	};

	typedef enum logic [1:0] {
		LM_LOCKED   = 2'd0,
		LM_OPEN     = 2'd1,
		LM_WARN     = 2'd2,
		LM_LOCKDOWN = 2'd3
	} lock_mode_t;

	typedef enum logic [1:0] {
		KP_IDLE     = 2'd0,
		KP_DEBOUNCE = 2'd1,
		KP_RELEASE  = 2'd2
	} key_phase_t;

	// Predicts the lock one tick at a time and checks the results in order
	class lock_scoreboard;
		logic [5:0]  user_code;
		logic [5:0]  admin_code;
		logic [7:0]  debounce_ticks;
		logic [15:0] open_ticks;
		logic [15:0] blink_half_ticks;
		logic [7:0]  warning_toggles;
		logic [17:0] lockdown_ticks;

		lock_mode_t  mode;
		key_phase_t  key_phase;
		logic [1:0]  cand_digit;
		logic [7:0]  press_count;
		int          digits;
		logic [5:0]  entry_shift;
		logic [1:0]  wrong_count;
		logic        warn_done;
		logic [17:0] phase_timer;
		logic [15:0] blink_timer;
		logic [7:0]  toggle_count;
		logic [2:0]  leds;

		kcl_result_t tick_results_q[$];
		int          errors;
		int          checked;
		int          events_seen[8];

		function new();
			user_code        = USER_CODE_RST;
			admin_code       = ADMIN_CODE_RST;
			debounce_ticks   = DEBOUNCE_RST;
			open_ticks       = OPEN_RST;
			blink_half_ticks = BLINK_HALF_RST;
			warning_toggles  = WARN_TOGGLE_RST;
			lockdown_ticks   = LOCKDOWN_RST;
			mode         = LM_LOCKED;
			key_phase    = KP_IDLE;
			cand_digit   = 2'd0;
			press_count  = 8'd0;
			digits       = 0;
			entry_shift  = 6'd0;
			wrong_count  = 2'd0;
			warn_done    = 1'b0;
			phase_timer  = 18'd0;
			blink_timer  = 16'd0;
			toggle_count = 8'd0;
			leds         = LED_R;
			errors  = 0;
			checked = 0;
			foreach (events_seen[i]) events_seen[i] = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [17:0] val);
			case (idx)
				REG_USER_CODE:   user_code        = val[5:0];
				REG_ADMIN_CODE:  admin_code       = val[5:0];
				REG_DEBOUNCE:    debounce_ticks   = val[7:0];
				REG_OPEN:        open_ticks       = val[15:0];
				REG_BLINK_HALF:  blink_half_ticks = val[15:0];
				REG_WARN_TOGGLE: warning_toggles  = val[7:0];
				REG_LOCKDOWN:    lockdown_ticks   = val;
				default: ;
			endcase
		endfunction

		function bit cand_held(logic [3:0] b);
			return (cand_digit == 2'd0) ? b[3] : b[cand_digit - 2'd1];
		endfunction

		// Follow the candidate button; return 1 on the release of a confirmed press
		function bit take_digit(logic [3:0] b, output logic [1:0] d);
			d = 2'd0;
			case (key_phase)
				KP_IDLE: begin
					if (b == 4'd0) return 1'b0;
					if (b[0]) cand_digit = 2'd1;
					else if (b[1]) cand_digit = 2'd2;
					else if (b[2]) cand_digit = 2'd3;
					else cand_digit = 2'd0;
					press_count = 8'd0;
					key_phase = (debounce_ticks == 8'd0) ? KP_RELEASE : KP_DEBOUNCE;
					return 1'b0;
				end
				KP_DEBOUNCE: begin
					if (!cand_held(b)) begin
						key_phase = KP_IDLE;
						return 1'b0;
					end
					if (press_count < 8'd255) press_count++;
					if (press_count >= debounce_ticks) key_phase = KP_RELEASE;
					return 1'b0;
				end
				default: begin
					if (cand_held(b)) return 1'b0;
					key_phase = KP_IDLE;
					d = cand_digit;
					return 1'b1;
				end
			endcase
		endfunction

		function kcl_result_t predict_tick(logic [3:0] b);
			logic [1:0]  d;
			logic        taken;
			logic        done;
			logic        admin_left;
			logic [5:0]  entry;
			logic [15:0] half;
			kcl_event_t  ev;
			kcl_result_t r;
			taken = 1'b0;
			done = 1'b0;
			admin_left = 1'b0;
			ev = EV_NONE;
			half = (blink_half_ticks == 16'd0) ? 16'd1 : blink_half_ticks;

			// Collect a digit while the keypad is live
			if (mode == LM_LOCKED || mode == LM_LOCKDOWN) begin
				if (take_digit(b, d)) begin
					taken = 1'b1;
					entry_shift = {entry_shift[3:0], d};
					digits++;
					done = (digits >= CODE_LEN);
				end
			end

			case (mode)
				LM_LOCKED: begin
					if (done) begin
						entry = entry_shift;
						digits = 0;
						entry_shift = 6'd0;
						if (entry == user_code) begin
							wrong_count = 2'd0;
							warn_done = 1'b0;
							mode = LM_OPEN;
							phase_timer = 18'd0;
							leds = LED_G;
							ev = EV_ACCEPTED;
						end else begin
							if (warn_done) wrong_count = 2'd3;
							else if (wrong_count < 2'd3) wrong_count++;
							warn_done = 1'b0;
							if (wrong_count == 2'd2) begin
								ev = EV_WARNING;
								key_phase = KP_IDLE;
								if (warning_toggles == 8'd0) begin
									leds = LED_R;
									warn_done = 1'b1;
								end else begin
									mode = LM_WARN;
									blink_timer = 16'd0;
									leds ^= LED_R;
									toggle_count = 8'd1;
								end
							end else if (wrong_count == 2'd3) begin
								ev = EV_LOCKDOWN;
								mode = LM_LOCKDOWN;
								phase_timer = 18'd0;
								blink_timer = 16'd0;
								leds |= LED_B;
							end else begin
								ev = EV_WRONG;
							end
						end
					end
				end
				LM_OPEN: begin
					if (phase_timer < TIMER_MAX) phase_timer++;
					if (phase_timer >= {2'b00, open_ticks}) begin
						mode = LM_LOCKED;
						leds = LED_R;
					end
				end
				LM_WARN: begin
					blink_timer++;
					if (blink_timer >= half) begin
						blink_timer = 16'd0;
						if (toggle_count >= warning_toggles) begin
							mode = LM_LOCKED;
							leds = LED_R;
							warn_done = 1'b1;
						end else begin
							leds ^= LED_R;
							toggle_count++;
						end
					end
				end
				default: begin
					// Admin code wins over a timeout on the same tick
					if (done) begin
						entry = entry_shift;
						digits = 0;
						entry_shift = 6'd0;
						if (entry == admin_code) begin
							wrong_count = 2'd0;
							warn_done = 1'b0;
							mode = LM_LOCKED;
							leds = LED_R;
							ev = EV_ADMIN_OK;
							admin_left = 1'b1;
						end else begin
							ev = EV_ADMIN_WRONG;
						end
					end
					if (!admin_left) begin
						if (phase_timer < TIMER_MAX) phase_timer++;
						blink_timer++;
						if (blink_timer >= half) begin
							blink_timer = 16'd0;
							leds ^= LED_R;
						end
						if (phase_timer >= lockdown_ticks) begin
							mode = LM_LOCKED;
							leds = LED_R;
							digits = 0;
							entry_shift = 6'd0;
							ev = EV_EXPIRED;
						end
					end
				end
			endcase

			r.led_green     = leds[0];
			r.led_blue      = leds[1];
			r.led_red       = leds[2];
			r.digit_taken   = taken;
			r.event_code    = ev;
			r.failure_count = wrong_count;
			return r;
		endfunction

		function void note_sample(logic [3:0] b);
			kcl_result_t r;
			r = predict_tick(b);
			events_seen[r.event_code]++;
			tick_results_q.push_back(r);
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10) $display("%s", msg);
		endfunction

		function void check_result(kcl_result_t got);
			kcl_result_t exp;
			if (tick_results_q.size() == 0) begin
				note_error($sformatf("%0t: result transfer with no sample pending", $realtime));
				return;
			end
			exp = tick_results_q.pop_front();
			checked++;
			if (got.led_green !== exp.led_green || got.led_blue !== exp.led_blue ||
			    got.led_red !== exp.led_red || got.digit_taken !== exp.digit_taken ||
			    got.event_code !== exp.event_code ||
			    got.failure_count !== exp.failure_count)
				note_error({
					$sformatf("%0t: mismatch on result %0d: ", $realtime, checked),
					$sformatf("expected g%b b%b r%b dt%b ev%0d fc%0d, ",
						exp.led_green, exp.led_blue, exp.led_red,
						exp.digit_taken, exp.event_code, exp.failure_count),
					$sformatf("got g%b b%b r%b dt%b ev%0d fc%0d",
						got.led_green, got.led_blue, got.led_red,
						got.digit_taken, got.event_code, got.failure_count)});
		endfunction

		function int pending();
			return tick_results_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [3:0]  buttons       = 4'd0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic        led_green;
	logic        led_blue;
	logic        led_red;
	logic        digit_taken;
	logic [2:0]  event_code;
	logic [1:0]  failure_count;
	logic        cfg_we        = 1'b0;
	logic [2:0]  cfg_index     = REG_USER_CODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	lock_scoreboard sb = new();
	int send_idle_pct = 25;
	int recv_idle_pct = 57;
	int hold_request  = 0;
	int items_sent    = 0;
	int settings_used = 0;

	keypad_code_lock_with_lockout dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.buttons       (buttons),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.led_green     (led_green),
		.led_blue      (led_blue),
		.led_red       (led_red),
		.digit_taken   (digit_taken),
		.event_code    (event_code),
		.failure_count (failure_count),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one sample, with random idle cycles ahead; return at the falling edge after the transfer
	task automatic send_sample(input logic [3:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			buttons <= 4'($urandom_range(15));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		buttons <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_sample(b);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and hold until every pending result has been taken
	task automatic quiesce();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [5:0] ucode, input logic [5:0] acode,
			input logic [7:0] deb, input logic [15:0] opn, input logic [15:0] blink,
			input logic [7:0] toggles, input logic [17:0] lockdown);
		quiesce();
		write_reg(REG_USER_CODE, {12'd0, ucode});
		write_reg(REG_ADMIN_CODE, {12'd0, acode});
		write_reg(REG_DEBOUNCE, {10'd0, deb});
		write_reg(REG_OPEN, {2'd0, opn});
		write_reg(REG_BLINK_HALF, {2'd0, blink});
		write_reg(REG_WARN_TOGGLE, {10'd0, toggles});
		write_reg(REG_LOCKDOWN, lockdown);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Press one digit long enough to confirm it, with optional bounce and lower-priority noise
	task automatic press_digit(input logic [1:0] d, input bit bounce);
		logic [3:0] key;
		logic [3:0] lower;
		int taps;
		case (d)
			2'd0: key = 4'b1000;
			2'd1: key = 4'b0001;
			2'd2: key = 4'b0010;
			default: key = 4'b0100;
		endcase
		lower = ~((key << 1) - 4'd1);
		if (bounce && sb.debounce_ticks != 8'd0) begin
			taps = (sb.debounce_ticks < 8'd4) ? int'(sb.debounce_ticks) : 4;
			repeat ($urandom_range(1, taps)) send_sample(key);
			send_sample(4'd0);
		end
		repeat (int'(sb.debounce_ticks) + 1 + $urandom_range(0, 3))
			send_sample(key | (4'($urandom) & lower));
		repeat ($urandom_range(1, 3)) send_sample(4'd0);
	endtask

	task automatic enter_code(input logic [5:0] code);
		for (int i = CODE_LEN - 1; i >= 0; i--)
			press_digit(code[2*i +: 2], $urandom_range(9) == 0);
	endtask

	function automatic logic [5:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 40) return sb.user_code;
		if (r < 70) return sb.admin_code;
		return 6'($urandom_range(63));
	endfunction

	// Mostly full code entries; the rest noise, quiet stretches, taps and partial codes
	task automatic random_action();
		int r;
		r = $urandom_range(99);
		if (r < 55) begin
			enter_code(pick_code());
		end else if (r < 67) begin
			repeat ($urandom_range(1, 6)) send_sample(4'($urandom_range(15)));
		end else if (r < 80) begin
			repeat ($urandom_range(1, 30)) send_sample(4'd0);
		end else if (r < 90) begin
			repeat ($urandom_range(1, 4)) send_sample(4'd1 << $urandom_range(0, 3));
			send_sample(4'd0);
		end else begin
			repeat ($urandom_range(1, 2)) press_digit(2'($urandom_range(3)), 1'b0);
		end
	endtask

	task automatic run_random(input int count);
		int stop;
		stop = items_sent + count;
		while (items_sent < stop) random_action();
	endtask

	// Drive the result stall: random stalls, or one long hold-off on request
	initial begin
		@(negedge clk);
		forever begin
			if (hold_request != 0) begin
				hold_request = 0;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
				@(negedge clk);
			end
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		kcl_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.led_green     = led_green;
			got.led_blue      = led_blue;
			got.led_red       = led_red;
			got.digit_taken   = digit_taken;
			got.event_code    = kcl_event_t'(event_code);
			got.failure_count = failure_count;
			sb.check_result(got);
		end
	end

	// End the run when no transfer happens for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("timeout: no transfer for %0d cycles, %0d results pending",
			WATCHDOG_LIMIT, sb.pending());
		$display("keypad_code_lock_with_lockout_tb: errors");
		$finish;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: fast keys, zero open time, zero warning toggles, zero blink,
		// admin code landing on the lockdown timeout tick
		program_regs(6'd27, 6'd0, 8'd0, 16'd0, 16'd0, 8'd0, 18'd6);
		for (int i = 30; i >= 0; i--) send_sample(OPENING_KEYS[i*4 +: 4]);

		// Short timers, sender and receiver both idle; one long result hold-off
		program_regs(6'($urandom_range(63)), 6'($urandom_range(63)), 8'd1, 16'd3, 16'd2,
			8'd2, 18'd30);
		run_random(20);
		hold_request = 1;
		run_random(20);

		// Debounce, open, toggles, lockdown and admin code at zero, shortest blink; pause once until all results are in
		program_regs(6'd63, 6'd0, 8'd0, 16'd0, 16'd1, 8'd0, 18'd0);
		run_random(15);
		quiesce();
		run_random(15);

		// Swap idling; codes at both extremes, open, blink, toggle and lockdown settings at maximum
		send_idle_pct = 57;
		recv_idle_pct = 25;
		program_regs(6'd0, 6'd63, 8'd2, 16'd65535, 16'd65535, 8'd255, TIMER_MAX);
		run_random(35);

		// Slowest debounce: one confirmed press and one bounce
		program_regs(6'($urandom_range(63)), 6'($urandom_range(63)), 8'd255, 16'd1, 16'd3,
			8'd5, 18'd12);
		press_digit(2'($urandom_range(3)), 1'b1);
		repeat (10) send_sample(4'b0100);
		send_sample(4'd0);

		// No idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_regs(6'($urandom_range(63)), 6'($urandom_range(63)), 8'($urandom_range(3)),
			16'($urandom_range(8)), 16'($urandom_range(1, 4)), 8'($urandom_range(4)),
			18'($urandom_range(10, 40)));
		run_random(40);
		program_regs(6'($urandom_range(63)), 6'($urandom_range(63)), 8'd1, 16'd2, 16'd1,
			8'd255, 18'd25);
		run_random(35);

		// Drain and let the result register settle
		quiesce();
		repeat (4) @(negedge clk);

		$display("Run covered %0d button samples, %0d register settings, %0d results.",
			items_sent, settings_used, sb.checked);
		$display("%s%s",
			$sformatf("Events: %0d open, %0d wrong, %0d warning, %0d lockdown, ",
				sb.events_seen[EV_ACCEPTED], sb.events_seen[EV_WRONG],
				sb.events_seen[EV_WARNING], sb.events_seen[EV_LOCKDOWN]),
			$sformatf("%0d admin ok, %0d admin wrong, %0d expired.",
				sb.events_seen[EV_ADMIN_OK], sb.events_seen[EV_ADMIN_WRONG],
				sb.events_seen[EV_EXPIRED]));
		if (sb.errors == 0 && sb.pending() == 0)
			$display("keypad_code_lock_with_lockout_tb: clean");
		else
			$display("keypad_code_lock_with_lockout_tb: errors");
		$finish;
	end

endmodule

### sim.f
rtl/kcl_pkg.sv
rtl/kcl_debounce.sv
rtl/kcl_ctrl.sv
rtl/keypad_code_lock_with_lockout.sv
tb/keypad_code_lock_with_lockout_tb.sv
